// ----- design/srbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbs_pkg
// Shared types and constants of the shift register button scanner.
// ----------------------------------------------------------------------------
package srbs_pkg;

  localparam int SHIFT_BITS_DEF  = 8;
  localparam int CAPTURE_W       = 8;
  localparam int SAMPLE_W        = CAPTURE_W + 1;
  localparam int TIMER_W         = 16;
  localparam int HALF_W          = 8;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;
  localparam int AUX1_BIT        = 7;

  localparam logic [HALF_W-1:0]  HALF_RST   = 8'd2;
  localparam logic [TIMER_W-1:0] SETTLE_RST = 16'd15000;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LOAD_LOW  = 3'd1,
    PH_LOAD_HIGH = 3'd2,
    PH_CLK_HIGH  = 3'd3,
    PH_CLK_LOW   = 3'd4,
    PH_SETTLE    = 3'd5
  } phase_t;

  typedef struct packed {
    logic                  enabled;
    logic [HALF_W-1:0]     half_ticks;
    logic [TIMER_W-1:0]    settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic                  load_level;
    logic                  clock_level;
    logic                  busy_res;
    logic                  press_valid;
    logic [SAMPLE_W-1:0]   pressed_mask;
    logic                  any_press;
  } result_t;

endpackage

// ----- design/srbs_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srbs_core
// Scan sequencer: phase, tick timer, bit capture and press edge detection.
// State advances one tick per accepted beat.
// ----------------------------------------------------------------------------
module srbs_core #(
  parameter int SHIFT_BITS = srbs_pkg::SHIFT_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             tick,
  input  logic             data_level,
  input  logic             start_level,
  input  logic             poll_request,
  input  srbs_pkg::cfg_t   cfg,
  output srbs_pkg::result_t res
);
  import srbs_pkg::*;

  localparam int BIT_W = (SHIFT_BITS > 1) ? $clog2(SHIFT_BITS) : 1;
  localparam logic [BIT_W:0] LAST_IDX = (BIT_W + 1)'(SHIFT_BITS - 1);

  phase_t               phase_r, phase_nxt;
  logic [TIMER_W-1:0]   timer_r, timer_nxt;
  logic [BIT_W-1:0]     bit_idx_r, bit_idx_nxt;
  logic [CAPTURE_W-1:0] capture_r, capture_nxt;
  logic [SAMPLE_W-1:0]  stable_r, stable_nxt;
  logic [SAMPLE_W-1:0]  prev_r, prev_nxt;
  logic                 rescan_r, rescan_nxt;

  logic [TIMER_W-1:0]   half_m1;
  logic [4:0]           idx_ext;
  logic [CAPTURE_W-1:0] capture_bit;
  logic                 more_bits;
  logic [SAMPLE_W-1:0]  sample;
  logic                 finish;
  logic [SAMPLE_W-1:0]  aux_clear;

  assign half_m1 = (cfg.half_ticks == '0) ? '0 :
                   TIMER_W'(cfg.half_ticks - HALF_W'(1));
  assign more_bits = ({1'b0, bit_idx_r} < LAST_IDX);
  assign sample    = {~start_level, capture_r};
  assign aux_clear = ~(SAMPLE_W'(1) << AUX1_BIT);

  // index used when the next data bit is taken
  always_comb begin
    if (phase_r == PH_CLK_LOW) begin
      idx_ext = 5'(bit_idx_r) + 5'd1;
    end else begin
      idx_ext = 5'd0;
    end
    capture_bit = '0;
    if (idx_ext < 5'(CAPTURE_W) && !data_level) begin
      capture_bit[idx_ext[2:0]] = 1'b1;
    end
  end

  // next state
  always_comb begin
    phase_nxt   = phase_r;
    timer_nxt   = timer_r;
    bit_idx_nxt = bit_idx_r;
    capture_nxt = capture_r;
    stable_nxt  = stable_r;
    prev_nxt    = prev_r;
    rescan_nxt  = rescan_r;
    finish      = 1'b0;
    unique case (phase_r)
      PH_LOAD_LOW: begin
        if (timer_r == '0) begin
          phase_nxt = PH_LOAD_HIGH;
          timer_nxt = half_m1;
        end else begin
          timer_nxt = timer_r - TIMER_W'(1);
        end
      end
      PH_LOAD_HIGH: begin
        if (timer_r == '0) begin
          capture_nxt = capture_r | capture_bit;
          phase_nxt   = PH_CLK_HIGH;
          timer_nxt   = half_m1;
        end else begin
          timer_nxt = timer_r - TIMER_W'(1);
        end
      end
      PH_CLK_HIGH: begin
        if (timer_r == '0) begin
          phase_nxt = PH_CLK_LOW;
          timer_nxt = half_m1;
        end else begin
          timer_nxt = timer_r - TIMER_W'(1);
        end
      end
      PH_CLK_LOW: begin
        if (timer_r != '0) begin
          timer_nxt = timer_r - TIMER_W'(1);
        end else if (more_bits) begin
          bit_idx_nxt = bit_idx_r + BIT_W'(1);
          capture_nxt = capture_r | capture_bit;
          phase_nxt   = PH_CLK_HIGH;
          timer_nxt   = half_m1;
        end else if (!rescan_r && sample != stable_r) begin
          stable_nxt = sample;
          rescan_nxt = 1'b1;
          if (cfg.settle_ticks == '0) begin
            phase_nxt   = PH_LOAD_LOW;
            timer_nxt   = half_m1;
            bit_idx_nxt = '0;
            capture_nxt = '0;
          end else begin
            phase_nxt = PH_SETTLE;
            timer_nxt = cfg.settle_ticks - TIMER_W'(1);
          end
        end else begin
          stable_nxt  = sample;
          rescan_nxt  = 1'b0;
          prev_nxt    = sample;
          finish      = 1'b1;
          phase_nxt   = PH_IDLE;
          timer_nxt   = '0;
          bit_idx_nxt = '0;
        end
      end
      PH_SETTLE: begin
        if (timer_r == '0) begin
          phase_nxt   = PH_LOAD_LOW;
          timer_nxt   = half_m1;
          bit_idx_nxt = '0;
          capture_nxt = '0;
        end else begin
          timer_nxt = timer_r - TIMER_W'(1);
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        if (poll_request && cfg.enabled) begin
          rescan_nxt  = 1'b0;
          phase_nxt   = PH_LOAD_LOW;
          timer_nxt   = half_m1;
          bit_idx_nxt = '0;
          capture_nxt = '0;
        end
      end
    endcase
  end

  // outputs, levels after this tick
  always_comb begin
    res.load_level   = (phase_nxt != PH_LOAD_LOW);
    res.clock_level  = (phase_nxt == PH_CLK_HIGH);
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.press_valid  = finish;
    res.pressed_mask = finish ? (sample & ~prev_r & aux_clear) : '0;
    res.any_press    = (res.pressed_mask != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      timer_r   <= '0;
      bit_idx_r <= '0;
      capture_r <= '0;
      stable_r  <= '0;
      prev_r    <= '0;
      rescan_r  <= 1'b0;
    end else if (tick) begin
      phase_r   <= phase_nxt;
      timer_r   <= timer_nxt;
      bit_idx_r <= bit_idx_nxt;
      capture_r <= capture_nxt;
      stable_r  <= stable_nxt;
      prev_r    <= prev_nxt;
      rescan_r  <= rescan_nxt;
    end
  end

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (bit_idx_r == '0 && timer_r == '0))
    else $error("idle with live counters");

  a_rescan_settle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SETTLE) |-> rescan_r)
    else $error("settle wait without pending rescan");

  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (tick && finish) |=> (phase_r == PH_IDLE && prev_r == stable_r))
    else $error("finished pass did not return to idle");

endmodule

// ----- design/shift_register_button_scanner_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shift_register_button_scanner_unit
// Tick-driven reader of a PISO button shift register plus a start pin,
// reporting newly pressed buttons once per completed poll.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat per timer tick carrying the data and start pin levels
//           and a poll request. Each accepted beat advances the scanner by
//           one tick and produces exactly one out_* beat.
//   out_* : pin drive levels after that tick, busy flag, and on the tick a
//           poll finishes press_valid with the newly pressed mask.
//   cfg_* : register writes (enable, half period, settle time), idle only.
// Timing: output beats leave the result register the cycle after acceptance.
//   Throughput: one beat per cycle while in_stall is low; the tick update is a
//   single pass of next-state logic between the state and result registers.
// Stall: while the result register is full and out_stall is high, in_stall
//   is raised and the tick state holds.
// Reset: scanner disabled, idle, stored samples cleared, half period 2 and
//   settle time 15000 ticks; the result register is empty.
// ----------------------------------------------------------------------------
module shift_register_button_scanner_unit #(
  parameter int SHIFT_BITS = srbs_pkg::SHIFT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_data_level,
  input  logic                              in_start_level,
  input  logic                              in_poll_request,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_load_level,
  output logic                              out_clock_level,
  output logic                              out_busy_res,
  output logic                              out_press_valid,
  output logic [srbs_pkg::SAMPLE_W-1:0]     out_pressed_mask,
  output logic                              out_any_press,
  input  logic                              cfg_we,
  input  logic [srbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srbs_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import srbs_pkg::*;

  cfg_t    cfg_r;
  result_t res;
  result_t res_r;
  logic    out_valid_r;
  logic    in_acc;

  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enabled      <= 1'b0;
      cfg_r.half_ticks   <= HALF_RST;
      cfg_r.settle_ticks <= SETTLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ENABLE: cfg_r.enabled      <= cfg_data[0];
        REG_HALF:   cfg_r.half_ticks   <= cfg_data[HALF_W-1:0];
        REG_SETTLE: cfg_r.settle_ticks <= cfg_data[TIMER_W-1:0];
        default: ;
      endcase
    end
  end

  srbs_core #(
    .SHIFT_BITS(SHIFT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .tick        (in_acc),
    .data_level  (in_data_level),
    .start_level (in_start_level),
    .poll_request(in_poll_request),
    .cfg         (cfg_r),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_load_level   = res_r.load_level;
  assign out_clock_level  = res_r.clock_level;
  assign out_busy_res     = res_r.busy_res;
  assign out_press_valid  = res_r.press_valid;
  assign out_pressed_mask = res_r.pressed_mask;
  assign out_any_press    = res_r.any_press;

  a_aux_masked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_pressed_mask[AUX1_BIT])
    else $error("aux1 bit reported");

  a_mask_only_on_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_press_valid) |-> (out_pressed_mask == '0 && !out_any_press))
    else $error("press mask outside finishing beat");

  a_any_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_any_press == (out_pressed_mask != '0)))
    else $error("any_press disagrees with mask");

  a_busy_levels: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy_res) |-> (out_load_level && !out_clock_level))
    else $error("pin levels active while not busy");

endmodule
